/* src/assert_macros.svh */
// Assertion helpers, clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PID_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define PID_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/pidaw_pkg.sv */
package pidaw_pkg;

  localparam int DATA_W    = 16;
  localparam int GAIN_FRAC = 8;
  localparam int PC_W      = 4;
  localparam int DIV_STEPS = 34;

  // register indexes
  localparam logic [2:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [2:0] REG_GAIN_INTEG  = 3'd1;
  localparam logic [2:0] REG_GAIN_DERIV  = 3'd2;
  localparam logic [2:0] REG_INTEG_LIMIT = 3'd3;
  localparam logic [2:0] REG_DRIVE_MIN   = 3'd4;
  localparam logic [2:0] REG_DRIVE_MAX   = 3'd5;

  // datapath operations
  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_ERR    = 4'd1;
  localparam logic [3:0] OP_MUL_GI = 4'd2;
  localparam logic [3:0] OP_MUL_DT = 4'd3;
  localparam logic [3:0] OP_INTEG  = 4'd4;
  localparam logic [3:0] OP_DIV    = 4'd5;
  localparam logic [3:0] OP_DSAT   = 4'd6;
  localparam logic [3:0] OP_MUL_GP = 4'd7;
  localparam logic [3:0] OP_MUL_GD = 4'd8;
  localparam logic [3:0] OP_SUM    = 4'd9;
  localparam logic [3:0] OP_OUT    = 4'd10;

  // jump conditions
  localparam logic [1:0] C_NONE = 2'd0;
  localparam logic [1:0] C_DTZ  = 2'd1;
  localparam logic [1:0] C_CNT  = 2'd2;

  typedef struct packed {
    logic [3:0]      op;
    logic [1:0]      cond;
    logic [PC_W-1:0] target;
    logic            last;
  } uword_t;

  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{op: OP_ERR,    cond: C_NONE, target: 4'd0, last: 1'b0};
      4'd1:    w = '{op: OP_MUL_GI, cond: C_NONE, target: 4'd0, last: 1'b0};
      4'd2:    w = '{op: OP_MUL_DT, cond: C_NONE, target: 4'd0, last: 1'b0};
      4'd3:    w = '{op: OP_INTEG,  cond: C_DTZ,  target: 4'd5, last: 1'b0};
      4'd4:    w = '{op: OP_DIV,    cond: C_CNT,  target: 4'd4, last: 1'b0};
      4'd5:    w = '{op: OP_DSAT,   cond: C_NONE, target: 4'd0, last: 1'b0};
      4'd6:    w = '{op: OP_MUL_GP, cond: C_NONE, target: 4'd0, last: 1'b0};
      4'd7:    w = '{op: OP_MUL_GD, cond: C_NONE, target: 4'd0, last: 1'b0};
      4'd8:    w = '{op: OP_SUM,    cond: C_NONE, target: 4'd0, last: 1'b0};
      4'd9:    w = '{op: OP_OUT,    cond: C_NONE, target: 4'd0, last: 1'b1};
      default: w = '{op: OP_NOP,    cond: C_NONE, target: 4'd0, last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

/* src/pid_controller_antiwindup_unit.sv */
// Fixed-point PID step with integral clamp, run by a ten-step microprogram over one shared
// 33x18 multiplier and a bit-serial restoring divider. A compute transfer is accepted and
// the step then runs until drive is offered; when period is zero the derivative division
// and its 34 divider iterations are skipped. in_ready is low while a step runs. A clear
// transfer (action 1) zeroes the integral and the previous error in the cycle it is
// accepted and gives no result. Write configuration only while idle.
`include "assert_macros.svh"

module pid_controller_antiwindup_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic signed [pidaw_pkg::DATA_W-1:0] in_target,
  input  logic signed [pidaw_pkg::DATA_W-1:0] in_sample,
  input  logic        [15:0]                  in_period,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pidaw_pkg::DATA_W-1:0] out_drive,
  input  logic                                cfg_we,
  input  logic        [2:0]                   cfg_index,
  input  logic        [30:0]                  cfg_data
);

  logic signed [15:0] gain_prop_r, gain_integ_r, gain_deriv_r;
  logic signed [15:0] drive_min_r, drive_max_r;
  logic        [30:0] integ_limit_r;

  logic                             busy_r;
  logic [pidaw_pkg::PC_W-1:0]       pc_r;
  logic signed [15:0]               tgt_r, smp_r;
  logic        [15:0]               dt_r;
  logic signed [16:0]               err_r, last_err_r;
  logic                             neg_r;
  logic        [33:0]               q_r;
  logic        [16:0]               rem_r;
  logic        [5:0]                cnt_r;
  logic signed [50:0]               prod_r, acc_r;
  logic signed [31:0]               integ_r, deriv_r;
  logic                             out_valid_r;
  logic signed [15:0]               out_drive_r;

  pidaw_pkg::uword_t uw;
  logic              step_go, jump;
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_p;
  logic signed [16:0] err_calc;
  logic signed [17:0] diff;
  logic        [17:0] mag;
  logic        [17:0] rem_sh;
  logic signed [34:0] qs;
  logic signed [50:0] isum, lim, ssum, dmin, dmax;
  logic signed [31:0] deriv_nxt;

  assign uw        = pidaw_pkg::ucode_rom(pc_r);
  assign in_ready  = !busy_r;
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  assign step_go = busy_r && !(uw.op == pidaw_pkg::OP_OUT && out_valid_r && !out_ready);
  assign jump    = (uw.cond == pidaw_pkg::C_DTZ && dt_r == 16'd0) ||
                   (uw.cond == pidaw_pkg::C_CNT && cnt_r != 6'd0);

  always_comb begin
    case (uw.op)
      pidaw_pkg::OP_MUL_GI: begin
        mul_a = 33'(err_r);
        mul_b = 18'(gain_integ_r);
      end
      pidaw_pkg::OP_MUL_DT: begin
        mul_a = prod_r[32:0];
        mul_b = $signed({2'b00, dt_r});
      end
      pidaw_pkg::OP_MUL_GP: begin
        mul_a = 33'(err_r);
        mul_b = 18'(gain_prop_r);
      end
      pidaw_pkg::OP_MUL_GD: begin
        mul_a = 33'(deriv_r);
        mul_b = 18'(gain_deriv_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign err_calc = {tgt_r[15], tgt_r} - {smp_r[15], smp_r};
  assign diff     = {err_calc[16], err_calc} - {last_err_r[16], last_err_r};
  assign mag      = diff[17] ? 18'(-diff) : 18'(diff);
  assign rem_sh   = {rem_r, q_r[33]};

  assign qs = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  always_comb begin
    if (dt_r == 16'd0) begin
      deriv_nxt = '0;
    end else if (qs[34:31] == 4'b0000 || qs[34:31] == 4'b1111) begin
      deriv_nxt = qs[31:0];
    end else if (qs[34]) begin
      deriv_nxt = {1'b1, 31'd0};
    end else begin
      deriv_nxt = {1'b0, {31{1'b1}}};
    end
  end

  assign lim  = $signed({20'd0, integ_limit_r});
  assign isum = 51'(integ_r) + (prod_r >>> pidaw_pkg::GAIN_FRAC);
  assign ssum = (acc_r >>> pidaw_pkg::GAIN_FRAC) + 51'(integ_r >>> 16);
  assign dmin = 51'(drive_min_r);
  assign dmax = 51'(drive_max_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r   <= '0;
      gain_integ_r  <= '0;
      gain_deriv_r  <= '0;
      integ_limit_r <= {31{1'b1}};
      drive_min_r   <= {1'b1, 15'd0};
      drive_max_r   <= {1'b0, {15{1'b1}}};
    end else if (cfg_we) begin
      case (cfg_index)
        pidaw_pkg::REG_GAIN_PROP:   gain_prop_r   <= cfg_data[15:0];
        pidaw_pkg::REG_GAIN_INTEG:  gain_integ_r  <= cfg_data[15:0];
        pidaw_pkg::REG_GAIN_DERIV:  gain_deriv_r  <= cfg_data[15:0];
        pidaw_pkg::REG_INTEG_LIMIT: integ_limit_r <= cfg_data;
        pidaw_pkg::REG_DRIVE_MIN:   drive_min_r   <= cfg_data[15:0];
        pidaw_pkg::REG_DRIVE_MAX:   drive_max_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      last_err_r  <= '0;
    end else begin
      if (step_go && uw.op == pidaw_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_valid && in_ready) begin
        if (in_action) begin
          integ_r    <= '0;
          last_err_r <= '0;
        end else begin
          busy_r <= 1'b1;
          pc_r   <= '0;
        end
      end
      if (step_go) begin
        if (uw.last) begin
          busy_r <= 1'b0;
          pc_r   <= '0;
        end else if (jump) begin
          pc_r <= uw.target;
        end else begin
          pc_r <= pc_r + 1'b1;
        end
        case (uw.op)
          pidaw_pkg::OP_ERR: last_err_r <= err_calc;
          pidaw_pkg::OP_INTEG: begin
            if (isum > lim) begin
              integ_r <= 32'(lim);
            end else if (isum < -lim) begin
              integ_r <= 32'(-lim);
            end else begin
              integ_r <= 32'(isum);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tgt_r <= in_target;
      smp_r <= in_sample;
      dt_r  <= in_period;
    end
    if (step_go) begin
      case (uw.op)
        pidaw_pkg::OP_ERR: begin
          err_r <= err_calc;
          neg_r <= diff[17];
          q_r   <= {mag, 16'd0};
          rem_r <= '0;
          cnt_r <= 6'(pidaw_pkg::DIV_STEPS - 1);
        end
        pidaw_pkg::OP_MUL_GI, pidaw_pkg::OP_MUL_DT, pidaw_pkg::OP_MUL_GP: begin
          prod_r <= mul_p;
        end
        pidaw_pkg::OP_DIV: begin
          cnt_r <= cnt_r - 1'b1;
          if (rem_sh >= {2'b00, dt_r}) begin
            rem_r <= 17'(rem_sh - {2'b00, dt_r});
            q_r   <= {q_r[32:0], 1'b1};
          end else begin
            rem_r <= rem_sh[16:0];
            q_r   <= {q_r[32:0], 1'b0};
          end
        end
        pidaw_pkg::OP_DSAT: deriv_r <= deriv_nxt;
        pidaw_pkg::OP_MUL_GD: begin
          acc_r  <= prod_r;
          prod_r <= mul_p;
        end
        pidaw_pkg::OP_SUM: acc_r <= acc_r + prod_r;
        pidaw_pkg::OP_OUT: begin
          if (ssum < dmin) begin
            out_drive_r <= drive_min_r;
          end else if (ssum > dmax) begin
            out_drive_r <= drive_max_r;
          end else begin
            out_drive_r <= 16'(ssum);
          end
        end
        default: ;
      endcase
    end
  end

  `PID_ASSERT(a_pc_idle, !busy_r, pc_r == '0)
  `PID_ASSERT(a_div_rem, busy_r && uw.op == pidaw_pkg::OP_DIV, rem_r < dt_r)
  `PID_ASSERT_NXT(a_clear, in_valid && in_ready && in_action, integ_r == '0 && last_err_r == '0)
  `PID_ASSERT_NXT(a_finish, busy_r && uw.last && !out_valid_r, out_valid_r && !busy_r)

endmodule
